@@ rtl/core/b64e_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned CharsPerJob = 4;

  localparam logic [6:0] PadChar = 7'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_item_t;

  // characters produced by one byte, count held as count minus one
  typedef struct packed {
    logic [CharsPerJob-1:0][6:0] chars;
    logic [1:0]                  n_m1;
    logic                        last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    logic [6:0] c;
    if (s < 6'd26) begin
      c = 7'h41 + {1'b0, s};
    end else if (s < 6'd52) begin
      c = 7'h61 + {1'b0, s} - 7'd26;
    end else if (s < 6'd62) begin
      c = 7'h30 + {1'b0, s} - 7'd52;
    end else if (s == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/b64e_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire b64e_pkg::in_item_t in_data_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output b64e_pkg::job_t          job_o
);
  import b64e_pkg::*;

  localparam logic [1:0] PhaseZero = 2'd0;
  localparam logic [1:0] PhaseOne  = 2'd1;
  localparam logic [1:0] PhaseTwo  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic [7:0] b;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign b          = in_data_i.data_byte;

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    job_o      = '0;
    job_o.last = in_data_i.last_byte;
    case (phase_q)
      PhaseOne: begin
        job_o.chars[0] = sextet_char({left_q[1:0], b[7:4]});
        if (in_data_i.last_byte) begin
          job_o.chars[1] = sextet_char({b[3:0], 2'b00});
          job_o.chars[2] = PadChar;
          job_o.n_m1     = 2'd2;
          phase_d        = PhaseZero;
          left_d         = '0;
        end else begin
          job_o.n_m1 = 2'd0;
          phase_d    = PhaseTwo;
          left_d     = b[3:0];
        end
      end
      PhaseTwo: begin
        job_o.chars[0] = sextet_char({left_q, b[7:6]});
        job_o.chars[1] = sextet_char(b[5:0]);
        job_o.n_m1     = 2'd1;
        phase_d        = PhaseZero;
        left_d         = '0;
      end
      default: begin
        // an unused phase code behaves as the start of a group
        job_o.chars[0] = sextet_char(b[7:2]);
        if (in_data_i.last_byte) begin
          job_o.chars[1] = sextet_char({b[1:0], 4'b0000});
          job_o.chars[2] = PadChar;
          job_o.chars[3] = PadChar;
          job_o.n_m1     = 2'd3;
          phase_d        = PhaseZero;
          left_d         = '0;
        end else begin
          job_o.n_m1 = 2'd0;
          phase_d    = PhaseOne;
          left_d     = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseZero;
      left_q  <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b64e_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire b64e_pkg::job_t job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output b64e_pkg::head_t     head_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == FullCnt);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop_i  ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b64e_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire b64e_pkg::head_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output b64e_pkg::out_item_t  out_data_o
);
  import b64e_pkg::*;

  logic      [1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  out_item_t       data_q, data_d;
  logic            advance, final_char;

  // output register frees when empty or taken this cycle
  assign advance    = head_i.valid && (!valid_q || out_ready_i);
  assign final_char = (idx_q == head_i.job.n_m1);
  assign pop_o      = advance && final_char;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q && !out_ready_i;
    data_d  = data_q;
    if (advance) begin
      valid_d          = 1'b1;
      data_d.char_code = head_i.job.chars[idx_q];
      data_d.last_char = head_i.job.last && final_char;
      idx_d            = final_char ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/core/base64_stream_encoder_top.sv @@
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_data_i  (raw byte, last flag)
// out      output     out_valid_o / out_ready_i out_data_o (ASCII char, last flag)
//
// A byte is taken and turned into one to four characters, queued as a job.
// Characters leave at one per cycle, while out_ready_i is high and a job is
// queued, from a single output register; a 3-byte group gives four characters.
// Reset empties the job queue and returns to the start of a group.
// Input stalls only when the job queue is full; out_ready_i low holds the
// output register while the front keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_top #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire b64e_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output b64e_pkg::out_item_t      out_data_o
);
  import b64e_pkg::*;

  logic  push, pop, q_full;
  job_t  job;
  head_t head;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_accept_fills_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> head.valid)
    else $error("accepted item left the job queue empty");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> head.valid)
    else $error("input stalled with an empty job queue");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("job popped from an empty queue");

endmodule

`default_nettype wire
